FILE: sv/assert_macros.svh
// Assertion macros shared by the blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/bb3_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box blur.
`default_nettype none
package bb3_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    typedef enum logic [1:0] {
        RD_COL = 2'd0,
        RD_DM1 = 2'd1,
        RD_D0  = 2'd2,
        RD_DP1 = 2'd3
    } rd_src_t;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef struct packed {
        logic    take;
        logic    rd_en;
        rd_src_t rd_src;
        logic    load;
        logic    acc_clr;
        logic    acc_add;
        logic [1:0] col_sel;
        logic    from_mem;
        logic    res_b;
        logic    mul;
        logic    put;
        logic    advance;
    } cmd_t;

    typedef struct packed {
        logic draining;
        logic r_ge1;
        logic c_ge1;
        logic c_ge2;
        logic c_last;
        logic d_ge1;
        logic d_last;
        logic out_free;
    } status_t;

    // ceil(2^16 / n); exact truncated quotient for sums below 8192
    function automatic logic [16:0] recip(input logic [3:0] n);
        logic [16:0] r;
        unique case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = 17'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: sv/box_blur_3x3_clipped.sv
// A pixel gives none, one or two results, each formed in the accumulate, multiply and output
// states after the load state; a drain item gives one, read and accumulated column by column.
// One item at a time: in_stall stays high until the sequencer is back in idle, and a full
// output register holds it in the output state. A pending register write holds off the input.
// Reset: positions clear, registers return to 1024 x 1024; line stores hold no reset value.
`default_nettype none
module box_blur_3x3_clipped (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  pixel_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       blurred,
    output logic [11:0]      out_row,
    output logic [9:0]       out_col,
    output logic             frame_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);
    bb3_pkg::cmd_t    cmd;
    bb3_pkg::status_t st;
    logic             cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    bb3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .st        (st),
        .cmd       (cmd)
    );

    bb3_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .pixel_in   (pixel_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .blurred    (blurred),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );
endmodule
`default_nettype wire

FILE: sv/bb3_dp.sv
// Datapath: line stores, column window, positions, accumulator, divider and output register.
`default_nettype none
`include "assert_macros.svh"
module bb3_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bb3_pkg::cmd_t   cmd,
    output bb3_pkg::status_t     st,
    input  wire logic [7:0]      pixel_in,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [12:0]     cfg_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           blurred,
    output logic [11:0]          out_row,
    output logic [9:0]           out_col,
    output logic                 frame_last
);
    logic [7:0]  older_mem [bb3_pkg::MAX_WIDTH];
    logic [7:0]  prior_mem [bb3_pkg::MAX_WIDTH];

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [11:0] row_reg;
    logic [9:0]  col_reg;
    logic [9:0]  drain_reg;
    logic        draining_reg;
    logic [23:0] win0_reg, win1_reg, win2_reg;
    logic [7:0]  pix_reg, top_q_reg, mid_q_reg;
    logic [11:0] sum_reg;
    logic [3:0]  cnt_reg;
    logic [28:0] prod_reg;
    logic        out_valid_reg;
    logic [7:0]  blurred_reg;
    logic [11:0] out_row_reg;
    logic [9:0]  out_col_reg;
    logic        frame_last_reg;

    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [9:0]  rd_addr;
    logic [23:0] col_word;
    logic        top_ok, bot_ok;
    logic [9:0]  add_sum;
    logic [3:0]  add_cnt;
    logic        c_last, r_last, d_last;
    logic        restart;

    always_comb
    begin
        if (width_reg == 11'd0)
            w_eff = 11'd1;
        else if (width_reg > 11'(bb3_pkg::MAX_WIDTH))
            w_eff = 11'(bb3_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == 13'd0)
            h_eff = 13'd1;
        else if (height_reg > 13'(bb3_pkg::MAX_HEIGHT))
            h_eff = 13'(bb3_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign c_last = ({1'b0, col_reg} + 11'd1) >= w_eff;
    assign d_last = ({1'b0, drain_reg} + 11'd1) == w_eff;
    assign r_last = ({1'b0, row_reg} + 13'd1) >= h_eff;

    assign st.draining = draining_reg;
    assign st.r_ge1    = row_reg >= 12'd1;
    assign st.c_ge1    = col_reg >= 10'd1;
    assign st.c_ge2    = col_reg >= 10'd2;
    assign st.c_last   = c_last;
    assign st.d_ge1    = drain_reg >= 10'd1;
    assign st.d_last   = d_last;
    assign st.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (cmd.rd_src)
            bb3_pkg::RD_COL: rd_addr = col_reg;
            bb3_pkg::RD_DM1: rd_addr = drain_reg - 10'd1;
            bb3_pkg::RD_D0:  rd_addr = drain_reg;
            bb3_pkg::RD_DP1: rd_addr = drain_reg + 10'd1;
            default:         rd_addr = col_reg;
        endcase
    end

    // Column word: top (row r-2), mid (row r-1), bottom (row r)
    always_comb
    begin
        if (cmd.from_mem)
            col_word = {top_q_reg, mid_q_reg, 8'd0};
        else
        begin
            unique case (cmd.col_sel)
                2'd0:    col_word = win0_reg;
                2'd1:    col_word = win1_reg;
                default: col_word = win2_reg;
            endcase
        end
        top_ok  = draining_reg ? (h_eff >= 13'd2) : (row_reg >= 12'd2);
        bot_ok  = !draining_reg;
        add_sum = {2'd0, col_word[15:8]}
                + (top_ok ? {2'd0, col_word[23:16]} : 10'd0)
                + (bot_ok ? {2'd0, col_word[7:0]} : 10'd0);
        add_cnt = 4'd1 + {3'd0, top_ok} + {3'd0, bot_ok};
    end

    // Line stores: read and write happen in different sequencer states
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            top_q_reg <= older_mem[rd_addr];
            mid_q_reg <= prior_mem[rd_addr];
        end
        if (cmd.load)
        begin
            older_mem[col_reg] <= mid_q_reg;
            prior_mem[col_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            pix_reg <= pixel_in;
        if (cmd.acc_clr)
        begin
            sum_reg <= 12'd0;
            cnt_reg <= 4'd0;
        end
        else if (cmd.acc_add)
        begin
            sum_reg <= sum_reg + {2'd0, add_sum};
            cnt_reg <= cnt_reg + add_cnt;
        end
        if (cmd.mul)
            prod_reg <= {17'd0, sum_reg} * {12'd0, bb3_pkg::recip(cnt_reg)};
        if (cmd.put)
        begin
            blurred_reg    <= prod_reg[23:16];
            frame_last_reg <= draining_reg && d_last;
            if (draining_reg)
            begin
                out_row_reg <= 12'(h_eff - 13'd1);
                out_col_reg <= drain_reg;
            end
            else
            begin
                out_row_reg <= row_reg - 12'd1;
                out_col_reg <= cmd.res_b ? col_reg : col_reg - 10'd1;
            end
        end
    end

    assign restart = cfg_we && (cfg_index == bb3_pkg::CFG_WIDTH
                                || cfg_index == bb3_pkg::CFG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 11'(bb3_pkg::MAX_WIDTH);
            height_reg    <= 13'd1024;
            row_reg       <= 12'd0;
            col_reg       <= 10'd0;
            drain_reg     <= 10'd0;
            draining_reg  <= 1'b0;
            win0_reg      <= 24'd0;
            win1_reg      <= 24'd0;
            win2_reg      <= 24'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.put)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cmd.load)
            begin
                win0_reg <= win1_reg;
                win1_reg <= win2_reg;
                win2_reg <= {top_q_reg, mid_q_reg, pix_reg};
            end

            if (restart)
            begin
                if (cfg_index == bb3_pkg::CFG_WIDTH)
                    width_reg <= cfg_data[10:0];
                else
                    height_reg <= cfg_data;
                row_reg      <= 12'd0;
                col_reg      <= 10'd0;
                drain_reg    <= 10'd0;
                draining_reg <= 1'b0;
            end
            else if (cmd.advance)
            begin
                if (draining_reg)
                begin
                    // drop back to the start of the next frame after the final output
                    if (d_last)
                    begin
                        row_reg      <= 12'd0;
                        col_reg      <= 10'd0;
                        drain_reg    <= 10'd0;
                        draining_reg <= 1'b0;
                    end
                    else
                        drain_reg <= drain_reg + 10'd1;
                end
                else if (c_last)
                begin
                    col_reg <= 10'd0;
                    if (r_last)
                    begin
                        draining_reg <= 1'b1;
                        drain_reg    <= 10'd0;
                    end
                    else
                        row_reg <= row_reg + 12'd1;
                end
                else
                    col_reg <= col_reg + 10'd1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign blurred    = blurred_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

    `ASSERT_IMPLY(a_mul_count, clk, rst_n, cmd.mul, cnt_reg >= 4'd1 && cnt_reg <= 4'd9)
    `ASSERT_IMPLY(a_mul_sum, clk, rst_n, cmd.mul, {1'b0, sum_reg} <= 13'd255 * {9'd0, cnt_reg})
    `ASSERT_NEXT(a_put_valid, clk, rst_n, cmd.put, out_valid_reg)
endmodule
`default_nettype wire

FILE: sv/bb3_ctrl.sv
// Sequencer: steps one pixel or drain item through load or read, accumulate, divide and output.
`default_nettype none
`include "assert_macros.svh"
module bb3_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             operation,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire bb3_pkg::status_t st,
    output bb3_pkg::cmd_t         cmd
);
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_ACC  = 7'b0000100,
        ST_DRD  = 7'b0001000,
        ST_DACC = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_PUT  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       resb_reg, resb_next;
    logic       accept;

    // a pending register write goes first; hold the input meanwhile
    assign in_stall  = state_reg != ST_IDLE || cfg_valid;
    assign cfg_ready = state_reg == ST_IDLE;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        resb_next   = resb_reg;
        cmd         = '0;
        cmd.rd_src  = bb3_pkg::RD_COL;
        cmd.col_sel = k_reg;
        cmd.res_b   = resb_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // a pixel while draining, or a drain while receiving, is dropped
                    if (!operation && !st.draining)
                    begin
                        cmd.take   = 1'b1;
                        cmd.rd_en  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else if (operation && st.draining)
                    begin
                        cmd.acc_clr = 1'b1;
                        k_next      = st.d_ge1 ? 2'd0 : 2'd1;
                        state_next  = ST_DRD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (st.r_ge1 && st.c_ge1)
                begin
                    cmd.acc_clr = 1'b1;
                    k_next      = st.c_ge2 ? 2'd0 : 2'd1;
                    resb_next   = 1'b0;
                    state_next  = ST_ACC;
                end
                else if (st.r_ge1 && st.c_last)
                begin
                    cmd.acc_clr = 1'b1;
                    k_next      = 2'd2;
                    resb_next   = 1'b1;
                    state_next  = ST_ACC;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (k_reg == 2'd2)
                    state_next = ST_MUL;
                else
                    k_next = k_reg + 2'd1;
            end
            ST_DRD:
            begin
                cmd.rd_en = 1'b1;
                unique case (k_reg)
                    2'd0:    cmd.rd_src = bb3_pkg::RD_DM1;
                    2'd1:    cmd.rd_src = bb3_pkg::RD_D0;
                    default: cmd.rd_src = bb3_pkg::RD_DP1;
                endcase
                state_next = ST_DACC;
            end
            ST_DACC:
            begin
                cmd.acc_add  = 1'b1;
                cmd.from_mem = 1'b1;
                if (k_reg == 2'd2 || (k_reg == 2'd1 && st.d_last))
                    state_next = ST_MUL;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_DRD;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                // hold until the output register is free
                if (st.out_free)
                begin
                    cmd.put = 1'b1;
                    if (!st.draining && !resb_reg && st.c_last)
                    begin
                        cmd.acc_clr = 1'b1;
                        k_next      = 2'd1;
                        resb_next   = 1'b1;
                        state_next  = ST_ACC;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
            resb_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            resb_reg  <= resb_next;
        end
    end

    `ASSERT_IMPLY(a_put_free, clk, rst_n, cmd.put, st.out_free)
    `ASSERT_NEXT(a_pix_load, clk, rst_n, accept && !operation && !st.draining,
                 state_reg == ST_LOAD)
    `ASSERT_NEXT(a_mul_put, clk, rst_n, state_reg == ST_MUL, state_reg == ST_PUT)
endmodule
`default_nettype wire

FILE: tb/box_blur_3x3_clipped_tb.sv
// Testbench for the clipped 3x3 box blur: random frames checked against a scoreboard predictor.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3_clipped_tb;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam logic       OP_PIXEL    = 1'b0;
    localparam logic       OP_DRAIN    = 1'b1;
    localparam int         CYCLE_LIMIT = 1500000;
    localparam int         SETTLE      = 30;

    typedef struct {
        logic [7:0]  blurred;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } blur_pixel_t;

    class blur_scoreboard;
        blur_pixel_t     expected_q[$];
        logic [7:0]      older_line[bb3_pkg::MAX_WIDTH];
        logic [7:0]      prior_line[bb3_pkg::MAX_WIDTH];
        logic [23:0]     window[3];
        int unsigned     row_pos, col_pos, drain_pos;
        bit              draining;
        int unsigned     width_reg, height_reg;
        int              errors;
        int              checked;
        int              frames_done;

        function new();
            width_reg = 1024;
            height_reg = 1024;
            window[0] = 0;
            window[1] = 0;
            window[2] = 0;
            errors = 0;
            checked = 0;
            frames_done = 0;
            restart();
        endfunction

        function void restart();
            row_pos = 0;
            col_pos = 0;
            drain_pos = 0;
            draining = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > bb3_pkg::MAX_WIDTH) return bb3_pkg::MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > bb3_pkg::MAX_HEIGHT) return bb3_pkg::MAX_HEIGHT;
            return height_reg;
        endfunction

        function void configure(input logic [1:0] idx, input logic [12:0] data);
            if (idx == bb3_pkg::CFG_WIDTH) begin
                width_reg = data[10:0];
                restart();
            end
            else if (idx == bb3_pkg::CFG_HEIGHT) begin
                height_reg = data;
                restart();
            end
        endfunction

        // middle byte always counts; upper and lower bytes only when in frame
        function void add_column(input logic [23:0] word, input bit top_ok, input bit bot_ok,
                                 inout int unsigned sum, inout int unsigned cnt);
            sum += word[15:8];
            cnt++;
            if (top_ok) begin
                sum += word[23:16];
                cnt++;
            end
            if (bot_ok) begin
                sum += word[7:0];
                cnt++;
            end
        endfunction

        function void push_mean(input int unsigned sum, input int unsigned cnt,
                                input int unsigned r, input int unsigned c, input bit last);
            blur_pixel_t e;
            e.blurred = 8'(sum / cnt);
            e.row = 12'(r);
            e.col = 10'(c);
            e.last = last;
            expected_q.push_back(e);
        endfunction

        function void note_input(input logic op, input logic [7:0] pix);
            int unsigned w, h, r, c, d, sum, cnt;
            logic [7:0] top, mid;
            bit top_ok;
            w = eff_width();
            h = eff_height();
            if (op == OP_PIXEL) begin
                if (draining) return;
                r = row_pos;
                c = col_pos;
                top = older_line[c];
                mid = prior_line[c];
                older_line[c] = mid;
                prior_line[c] = pix;
                window[0] = window[1];
                window[1] = window[2];
                window[2] = {top, mid, pix};
                if (r >= 1) begin
                    top_ok = (r >= 2);
                    if (c >= 1) begin
                        sum = 0;
                        cnt = 0;
                        if (c >= 2) add_column(window[0], top_ok, 1'b1, sum, cnt);
                        add_column(window[1], top_ok, 1'b1, sum, cnt);
                        add_column(window[2], top_ok, 1'b1, sum, cnt);
                        push_mean(sum, cnt, r - 1, c - 1, 1'b0);
                    end
                    if (c + 1 == w) begin
                        sum = 0;
                        cnt = 0;
                        if (c >= 1) add_column(window[1], top_ok, 1'b1, sum, cnt);
                        add_column(window[2], top_ok, 1'b1, sum, cnt);
                        push_mean(sum, cnt, r - 1, c, 1'b0);
                    end
                end
                if (c + 1 >= w) begin
                    col_pos = 0;
                    if (r + 1 >= h) begin
                        draining = 1;
                        drain_pos = 0;
                    end
                    else begin
                        row_pos = r + 1;
                    end
                end
                else begin
                    col_pos = c + 1;
                end
                return;
            end
            if (!draining) return;
            d = drain_pos;
            top_ok = (h >= 2);
            if (d >= w) begin
                restart();
                return;
            end
            sum = 0;
            cnt = 0;
            if (d >= 1) add_column({older_line[d-1], prior_line[d-1], 8'h00}, top_ok, 1'b0,
                                   sum, cnt);
            add_column({older_line[d], prior_line[d], 8'h00}, top_ok, 1'b0, sum, cnt);
            if (d + 1 < w) add_column({older_line[d+1], prior_line[d+1], 8'h00}, top_ok, 1'b0,
                                      sum, cnt);
            push_mean(sum, cnt, h - 1, d, d + 1 == w);
            if (d + 1 == w) begin
                restart();
                frames_done++;
            end
            else begin
                drain_pos = d + 1;
            end
        endfunction

        function void check_result(input logic [7:0] blurred, input logic [11:0] row,
                                   input logic [9:0] col, input logic last);
            blur_pixel_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected output blurred=%0d row=%0d col=%0d last=%0b",
                             blurred, row, col, last);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (blurred !== e.blurred || row !== e.row || col !== e.col || last !== e.last) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected blurred=%0d row=%0d col=%0d last=%0b, got %0d %0d %0d %0b",
                             e.blurred, e.row, e.col, e.last, blurred, row, col, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = 1'b0;
    logic [7:0]  pixel_in = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  blurred;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        frame_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [12:0] cfg_data = 13'd0;

    blur_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  cur_w, cur_h;

    box_blur_3x3_clipped u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .blurred(blurred), .out_row(out_row), .out_col(out_col), .frame_last(frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // observe every transfer at the edge it happens
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.configure(cfg_index, cfg_data);
            if (in_valid && !in_stall) sb.note_input(operation, pixel_in);
            if (out_valid && !out_stall) sb.check_result(blurred, out_row, out_col, frame_last);
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] pix);
        in_valid <= 1'b1;
        operation <= op;
        pixel_in <= pix;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            operation <= 1'($urandom);
            pixel_in <= 8'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        wait_results();
        // let a pixel that makes no result finish its pass
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= 13'($urandom);
    endtask

    task automatic set_frame(input logic [10:0] wdata, input logic [12:0] hdata);
        write_reg(bb3_pkg::CFG_WIDTH, {2'($urandom), wdata});
        write_reg(bb3_pkg::CFG_HEIGHT, hdata);
        cur_w = (wdata == 0) ? 1 : (wdata > bb3_pkg::MAX_WIDTH) ? bb3_pkg::MAX_WIDTH : wdata;
        cur_h = (hdata == 0) ? 1 : (hdata > bb3_pkg::MAX_HEIGHT) ? bb3_pkg::MAX_HEIGHT : hdata;
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // send npix pixels of the current frame, then drain if the frame is complete
    task automatic run_frame(input int npix, input bit noisy);
        for (int i = 0; i < npix; i++) begin
            if (noisy && $urandom_range(19) == 0) send_item(OP_DRAIN, 8'($urandom));
            send_item(OP_PIXEL, pick_pixel());
        end
        if (npix == cur_w * cur_h) begin
            for (int d = 0; d < cur_w; d++) begin
                if (noisy && $urandom_range(19) == 0) send_item(OP_PIXEL, 8'($urandom));
                send_item(OP_DRAIN, 8'($urandom));
            end
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int target,
                             input bit hold, input bit pause);
        int start;
        start = items_sent;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        // a frame cut short and a clamped height
        set_frame(11'($urandom_range(3, 6)), 13'd8191);
        run_frame($urandom_range(5, 20), 1'b1);
        while (items_sent - start < target) begin
            set_frame(11'($urandom_range(1, 8)), 13'($urandom_range(1, 5)));
            if (hold && items_sent - start > target / 2) begin
                hold_req++;
                hold = 0;
            end
            if (pause && items_sent - start > target / 2) begin
                wait_results();
                pause = 0;
            end
            run_frame(cur_w * cur_h, 1'b1);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, drain before any pixel, pixel during drain
        set_frame(11'd0, 13'd0);
        send_item(OP_DRAIN, 8'd0);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd7);
        send_item(OP_DRAIN, 8'd255);
        set_frame(11'd3, 13'd3);
        for (int i = 0; i < 9; i++) send_item(OP_PIXEL, (i % 2 == 0) ? 8'd255 : 8'd0);
        for (int d = 0; d < 3; d++) send_item(OP_DRAIN, 8'($urandom));
        write_reg(CFG_SPARE_A, 13'($urandom));
        write_reg(CFG_SPARE_B, 13'($urandom));
        set_frame(11'd2, 13'd2);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_DRAIN, 8'd0);
        send_item(OP_DRAIN, 8'd0);

        run_phase(0, 0, 110, 1'b0, 1'b0);
        run_phase(62, 0, 110, 1'b0, 1'b1);
        run_phase(0, 62, 110, 1'b1, 1'b0);
        run_phase(33, 33, 110, 1'b0, 1'b0);

        // widest rows, started but cut short: clamped width register, then exact maximum
        tx_idle_pct = 0;
        rx_stall_pct = 20;
        set_frame(11'h7FF, 13'd2);
        run_frame(40, 1'b0);
        set_frame(11'd1024, 13'd4096);
        run_frame(40, 1'b0);
        write_reg(CFG_SPARE_B, 13'h1FFF);
        write_reg(CFG_SPARE_A, 13'h0000);

        wait_results();
        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d items over %0d complete frames; %0d output pixels checked.",
                 items_sent, sb.frames_done, sb.checked);
        $display("Covered full frames 1x1 to 8x5, partial 1024-wide rows, spare register writes, and stall phases.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("%0d mismatches, %0d results still expected", sb.errors, sb.pending());
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
